// ===== rtl/core/wmu_pkg.sv =====
// Shared constants, operation codes, a control type and a saturation helper
// for the skeleton world-matrix update block. Depends on nothing.
`default_nettype none
package wmu_pkg;

  localparam int MAX_NODES = 64;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int ELEM_W    = 4;
  localparam int ADDR_W    = NODE_W + ELEM_W;
  localparam int CNT_W     = 7;
  localparam int ACC_W     = DATA_W + 2;
  localparam int PROD_W    = 2 * DATA_W;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(MAX_NODES);

  localparam logic [2:0] OP_ROOT   = 3'd0;
  localparam logic [2:0] OP_LOCAL  = 3'd1;
  localparam logic [2:0] OP_LINK   = 3'd2;
  localparam logic [2:0] OP_UPDATE = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

  function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
    lo = -hi - PROD_W'(1);
    if (x > hi) begin
      sat_word = hi[DATA_W-1:0];
    end else if (x < lo) begin
      sat_word = lo[DATA_W-1:0];
    end else begin
      sat_word = x[DATA_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wmu_mac.sv =====
// Shared multiply and saturating accumulate unit for one dot product.
// Depends on wmu_pkg.
`default_nettype none
module wmu_mac (
  input  wire logic                             clk,
  input  wire wmu_pkg::mac_ctrl_t               ctrl,
  input  wire logic signed [wmu_pkg::DATA_W-1:0] a,
  input  wire logic signed [wmu_pkg::DATA_W-1:0] b,
  output logic signed [wmu_pkg::DATA_W-1:0]     sum
);

  logic signed [wmu_pkg::PROD_W-1:0] prod;
  logic signed [wmu_pkg::ACC_W-1:0]  acc;
  logic signed [wmu_pkg::DATA_W-1:0] term;

  assign term = wmu_pkg::sat_word(prod >>> wmu_pkg::FRAC_BITS);
  assign sum  = wmu_pkg::sat_word(wmu_pkg::PROD_W'(acc));

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= wmu_pkg::PROD_W'(a) * wmu_pkg::PROD_W'(b);
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + wmu_pkg::ACC_W'(term);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/skeleton_world_matrix_update.sv =====
// Top level: host command decode, matrix and link stores, and the update
// sequencer driving the shared multiply-accumulate unit. Depends on wmu_pkg
// and wmu_mac.
//
// Root, local and link writes, world reads and unused operation codes leave
// busy low: the result word appears on the cycle after start. An update
// holds busy high while it computes node 0 and then each further link
// position whose child and parent are in range, skipping the others. Each of
// the sixteen elements needs four passes through the address, multiply and
// accumulate states of the single multiplier and a sum state to store it,
// the sixteen results are copied into the world store one a cycle, and each
// further position first fetches and checks its link.
// The receiver cannot stall; every result word is shown for one cycle with done.
`default_nettype none
module skeleton_world_matrix_update (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [2:0]                       operation,
  input  wire logic [wmu_pkg::NODE_W-1:0]       node,
  input  wire logic [wmu_pkg::ELEM_W-1:0]       element,
  input  wire logic signed [wmu_pkg::DATA_W-1:0] value,
  input  wire logic [wmu_pkg::NODE_W-1:0]       position,
  input  wire logic [wmu_pkg::NODE_W-1:0]       parent,
  input  wire logic                             cfg_we,
  input  wire logic [wmu_pkg::CNT_W-1:0]        cfg_data,
  output logic                                  done,
  output logic signed [wmu_pkg::DATA_W-1:0]     read_data,
  output logic                                  status
);

  typedef enum logic [2:0] {
    S_IDLE, S_LINK_REQ, S_LINK_CHK, S_ADDR, S_MUL, S_ACC, S_SUM, S_COPY
  } state_t;

  localparam int NODES = wmu_pkg::MAX_NODES;
  localparam int DEPTH = NODES * 16;

  state_t state;
  logic [wmu_pkg::CNT_W-1:0]  node_count;
  logic [wmu_pkg::CNT_W-1:0]  n_eff;
  logic [wmu_pkg::CNT_W-1:0]  pos;
  logic [wmu_pkg::CNT_W-1:0]  pos_next;
  logic [wmu_pkg::NODE_W-1:0] child_r;
  logic [wmu_pkg::NODE_W-1:0] par_r;
  logic [3:0]                 e;
  logic [1:0]                 k;
  logic                       first;
  logic                       rd_sel;

  logic signed [wmu_pkg::DATA_W-1:0] root_mem [16];
  logic signed [wmu_pkg::DATA_W-1:0] local_mem [DEPTH];
  logic signed [wmu_pkg::DATA_W-1:0] world_mem [DEPTH];
  logic [2*wmu_pkg::NODE_W-1:0]      link_mem [NODES];
  logic signed [wmu_pkg::DATA_W-1:0] temp [16];

  logic signed [wmu_pkg::DATA_W-1:0] root_q;
  logic signed [wmu_pkg::DATA_W-1:0] local_q;
  logic signed [wmu_pkg::DATA_W-1:0] world_q;
  logic [2*wmu_pkg::NODE_W-1:0]      link_q;
  logic [wmu_pkg::ADDR_W-1:0]        world_raddr;
  logic [wmu_pkg::NODE_W-1:0]        link_child;
  logic [wmu_pkg::NODE_W-1:0]        link_par;

  logic                       accept;
  logic                       node_bad;
  logic                       link_bad;
  wmu_pkg::mac_ctrl_t         mac_ctrl;
  logic signed [wmu_pkg::DATA_W-1:0] mac_a;
  logic signed [wmu_pkg::DATA_W-1:0] mac_sum;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign n_eff  = (node_count == '0) ? wmu_pkg::CNT_W'(1) :
                  (node_count > wmu_pkg::COUNT_LIMIT) ? wmu_pkg::COUNT_LIMIT : node_count;
  assign node_bad = ({1'b0, node} >= n_eff);
  assign link_bad = node_bad || ({1'b0, position} >= n_eff) || ({1'b0, parent} >= n_eff);
  assign link_child = link_q[2*wmu_pkg::NODE_W-1:wmu_pkg::NODE_W];
  assign link_par   = link_q[wmu_pkg::NODE_W-1:0];
  assign world_raddr = busy ? {par_r, k, e[1:0]} : {node, element};
  assign pos_next   = first ? wmu_pkg::CNT_W'(1) : pos + wmu_pkg::CNT_W'(1);
  assign mac_a      = first ? root_q : world_q;
  assign read_data  = rd_sel ? world_q : '0;

  assign mac_ctrl.clear  = (state == S_SUM) || (state == S_IDLE);
  assign mac_ctrl.mul_en = (state == S_MUL);
  assign mac_ctrl.acc_en = (state == S_ACC);

  wmu_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (local_q),
    .sum  (mac_sum)
  );

  always_ff @(posedge clk) begin
    root_q  <= root_mem[{k, e[1:0]}];
    local_q <= local_mem[{child_r, e[3:2], k}];
    world_q <= world_mem[world_raddr];
    link_q  <= link_mem[pos[wmu_pkg::NODE_W-1:0]];
    if (accept && operation == wmu_pkg::OP_ROOT) begin
      root_mem[element] <= value;
    end
    if (accept && operation == wmu_pkg::OP_LOCAL && !node_bad) begin
      local_mem[{node, element}] <= value;
    end
    if (accept && operation == wmu_pkg::OP_LINK && !link_bad) begin
      link_mem[position] <= {node, parent};
    end
    if (state == S_COPY) begin
      world_mem[{child_r, e}] <= temp[e];
    end
    if (state == S_SUM) begin
      temp[e] <= mac_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= wmu_pkg::CNT_W'(1);
      done       <= 1'b0;
      status     <= 1'b0;
      rd_sel     <= 1'b0;
      pos        <= '0;
      e          <= '0;
      k          <= '0;
      first      <= 1'b0;
      child_r    <= '0;
      par_r      <= '0;
    end else begin
      done   <= 1'b0;
      status <= 1'b0;
      rd_sel <= 1'b0;
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (operation == wmu_pkg::OP_UPDATE) begin
              state   <= S_ADDR;
              first   <= 1'b1;
              child_r <= '0;
              par_r   <= '0;
              e       <= '0;
              k       <= '0;
              pos     <= '0;
            end else begin
              done <= 1'b1;
              case (operation)
                wmu_pkg::OP_LOCAL: status <= node_bad;
                wmu_pkg::OP_LINK:  status <= link_bad;
                wmu_pkg::OP_READ: begin
                  status <= node_bad;
                  rd_sel <= !node_bad;
                end
                default: status <= 1'b0;
              endcase
            end
          end
        end
        S_LINK_REQ: state <= S_LINK_CHK;
        S_LINK_CHK: begin
          if (({1'b0, link_child} < n_eff) && ({1'b0, link_par} < n_eff)) begin
            child_r <= link_child;
            par_r   <= link_par;
            e       <= '0;
            k       <= '0;
            state   <= S_ADDR;
          end else if (pos + wmu_pkg::CNT_W'(1) >= n_eff) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            pos   <= pos + wmu_pkg::CNT_W'(1);
            state <= S_LINK_REQ;
          end
        end
        S_ADDR: state <= S_MUL;
        S_MUL:  state <= S_ACC;
        S_ACC: begin
          if (k == 2'd3) begin
            state <= S_SUM;
          end else begin
            k     <= k + 2'd1;
            state <= S_ADDR;
          end
        end
        S_SUM: begin
          k <= '0;
          if (e == 4'd15) begin
            e     <= '0;
            state <= S_COPY;
          end else begin
            e     <= e + 4'd1;
            state <= S_ADDR;
          end
        end
        S_COPY: begin
          e <= e + 4'd1;
          if (e == 4'd15) begin
            first <= 1'b0;
            if (pos_next >= n_eff) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              pos   <= pos_next;
              state <= S_LINK_REQ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wmu_checker.sv =====
// Port-level checker for the skeleton world-matrix update block, with its
// bind to the top level. Depends on wmu_pkg.
`default_nettype none
module wmu_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic [2:0]                       operation,
  input wire logic                             done,
  input wire logic signed [wmu_pkg::DATA_W-1:0] read_data,
  input wire logic                             status
);

  a_update_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == wmu_pkg::OP_UPDATE) |=> (busy && !done))
    else $error("Update word did not raise busy.");

  a_short_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation != wmu_pkg::OP_UPDATE) |=> (done && !busy))
    else $error("Short command word gave no result on the next cycle.");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (!done || status) |-> (read_data == '0))
    else $error("Read data not zero outside a good read result.");

  a_done_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("Update finished without a result word.");

endmodule

bind skeleton_world_matrix_update wmu_checker u_wmu_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .done      (done),
  .read_data (read_data),
  .status    (status)
);
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for skeleton_world_matrix_update: a command driver, a
// result monitor and a predictor of the matrix hierarchy, with directed and random words.
// Depends on wmu_pkg and the block's RTL.
module tb;

  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic [5:0]         node;
    logic [3:0]         elem;
    logic signed [31:0] value;
    logic [5:0]         pos;
    logic [5:0]         par;
  } cmd_t;

  typedef struct {
    logic signed [31:0] data;
    logic               st;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] operation = '0;
  logic [5:0] node = '0;
  logic [3:0] element = '0;
  logic signed [31:0] value = '0;
  logic [5:0] position = '0;
  logic [5:0] parent = '0;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;
  logic busy, done, status;
  logic signed [31:0] read_data;

  skeleton_world_matrix_update dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .node(node), .element(element), .value(value), .position(position),
    .parent(parent), .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done),
    .read_data(read_data), .status(status)
  );

  cmd_t   pending_cmds[$];
  reply_t expected_replies[$];
  int     failures = 0;
  int     idle_pct = 20;

  // Predicted contents of the block.
  logic signed [31:0] pr_root [16];
  logic signed [31:0] pr_local [1024];
  logic signed [31:0] pr_world [1024];
  logic [5:0] pr_child [64];
  logic [5:0] pr_par [64];
  int pr_count = 1;

  // What the stimulus has written so far, so that no unwritten entry is ever read.
  bit root_wr [16];
  bit loc_wr [64][16];
  bit world_ok [64];
  bit link_ok [64];
  logic [5:0] lk_child [64];
  logic [5:0] lk_par [64];
  int gen_n = 1;
  int issued = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] fixed_mul(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat64(p >>> wmu_pkg::FRAC_BITS);
  endfunction

  // dst = a * b, column major; windows of 16 at the bases, a from pr_root if from_root.
  task automatic world_product(input bit from_root, input int a_base, input int b_base,
                               input int d_base);
    logic signed [31:0] t [16];
    logic signed [31:0] av;
    logic signed [63:0] acc;
    for (int col = 0; col < 4; col++) begin
      for (int row = 0; row < 4; row++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          av = from_root ? pr_root[4*k+row] : pr_world[a_base+4*k+row];
          acc += 64'(fixed_mul(av, pr_local[b_base+4*col+k]));
        end
        t[4*col+row] = sat64(acc);
      end
    end
    for (int e = 0; e < 16; e++) pr_world[d_base+e] = t[e];
  endtask

  task automatic predict(input cmd_t c);
    reply_t r;
    int n;
    n = pr_count;
    r.data = '0;
    r.st = 1'b0;
    case (c.op)
      wmu_pkg::OP_ROOT: pr_root[c.elem] = c.value;
      wmu_pkg::OP_LOCAL: begin
        if (c.node >= n) r.st = 1'b1;
        else pr_local[c.node*16+c.elem] = c.value;
      end
      wmu_pkg::OP_LINK: begin
        if (c.pos >= n || c.node >= n || c.par >= n) begin
          r.st = 1'b1;
        end else begin
          pr_child[c.pos] = c.node;
          pr_par[c.pos] = c.par;
        end
      end
      wmu_pkg::OP_UPDATE: begin
        world_product(1'b1, 0, 0, 0);
        for (int p = 1; p < n; p++) begin
          if (pr_child[p] < n && pr_par[p] < n)
            world_product(1'b0, pr_par[p]*16, pr_child[p]*16, pr_child[p]*16);
        end
      end
      wmu_pkg::OP_READ: begin
        if (c.node >= n) r.st = 1'b1;
        else r.data = pr_world[c.node*16+c.elem];
      end
      default: ;
    endcase
    expected_replies.push_back(r);
  endtask

  always @(posedge clk) begin
    cmd_t c;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        c.op = operation; c.node = node; c.elem = element; c.value = value;
        c.pos = position; c.par = parent;
        predict(c);
      end
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
          c = pending_cmds.pop_front();
          operation <= c.op; node <= c.node; element <= c.elem; value <= c.value;
          position <= c.pos; parent <= c.par;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    reply_t e;
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result word: read_data %0d status %0d", read_data, status);
        failures++;
      end else begin
        e = expected_replies.pop_front();
        if (read_data !== e.data) begin
          $error("read_data: expected %0d, got %0d", e.data, read_data);
          failures++;
        end
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status);
          failures++;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(3))
      0: return $urandom;
      3: begin
        case ($urandom_range(5))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h00000000;
          3: return 32'hffffffff;
          4: return 32'h00010000;
          default: return 32'hffff0000;
        endcase
      end
      default: return $signed(32'($urandom_range(0, 1 << 19))) - 32'sd262144;
    endcase
  endfunction

  function automatic bit local_full(input int k);
    for (int e = 0; e < 16; e++) if (!loc_wr[k][e]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_node(input int lim);
    if (lim >= 64) return $urandom_range(63);
    if ($urandom_range(3) != 0) return $urandom_range(lim - 1);
    return $urandom_range(63);
  endfunction

  task automatic push(input logic [2:0] op, input int nd, input int el,
                      input logic signed [31:0] v, input int ps, input int pa);
    cmd_t c;
    c.op = op; c.node = 6'(nd); c.elem = 4'(el); c.value = v; c.pos = 6'(ps);
    c.par = 6'(pa);
    pending_cmds.push_back(c);
    issued++;
    case (op)
      wmu_pkg::OP_ROOT: root_wr[el] = 1'b1;
      wmu_pkg::OP_LOCAL: if (nd < gen_n) loc_wr[nd][el] = 1'b1;
      wmu_pkg::OP_LINK: begin
        if (ps < gen_n && nd < gen_n && pa < gen_n) begin
          link_ok[ps] = 1'b1; lk_child[ps] = 6'(nd); lk_par[ps] = 6'(pa);
        end
      end
      wmu_pkg::OP_UPDATE: begin
        world_ok[0] = 1'b1;
        for (int p = 1; p < gen_n; p++)
          if (lk_child[p] < gen_n && lk_par[p] < gen_n) world_ok[lk_child[p]] = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic write_matrix(input int nd);
    for (int e = 0; e < 16; e++) push(wmu_pkg::OP_LOCAL, nd, e, rand_val(), 0, 0);
  endtask

  // Fills in whatever an update would read before it is written, then issues the update.
  task automatic safe_update();
    bit ok [64];
    int c, q;
    for (int e = 0; e < 16; e++)
      if (!root_wr[e]) push(wmu_pkg::OP_ROOT, 0, e, rand_val(), 0, 0);
    for (int e = 0; e < 16; e++)
      if (!loc_wr[0][e]) push(wmu_pkg::OP_LOCAL, 0, e, rand_val(), 0, 0);
    ok = world_ok;
    ok[0] = 1'b1;
    for (int p = 1; p < gen_n; p++) begin
      if (!link_ok[p] || (lk_child[p] < gen_n && lk_par[p] < gen_n &&
          (!local_full(lk_child[p]) || !ok[lk_par[p]]))) begin
        c = 0;
        q = 0;
        for (int t = 0; t < 8; t++) begin
          c = $urandom_range(gen_n - 1);
          if (local_full(c)) break;
          c = 0;
        end
        for (int t = 0; t < 8; t++) begin
          q = $urandom_range(gen_n - 1);
          if (ok[q]) break;
          q = 0;
        end
        push(wmu_pkg::OP_LINK, c, 0, $urandom, p, q);
      end
      if (lk_child[p] < gen_n && lk_par[p] < gen_n) ok[lk_child[p]] = 1'b1;
    end
    push(wmu_pkg::OP_UPDATE, $urandom_range(63), $urandom_range(15), $urandom,
         $urandom_range(63), $urandom_range(63));
  endtask

  task automatic safe_read();
    int k;
    k = -1;
    if ($urandom_range(4) != 0) begin
      for (int t = 0; t < 10; t++) begin
        k = $urandom_range(gen_n - 1);
        if (world_ok[k]) break;
        k = -1;
      end
    end
    if (k < 0 && gen_n < 64) k = $urandom_range(gen_n, 63);
    if (k >= 0) push(wmu_pkg::OP_READ, k, $urandom_range(15), $urandom, $urandom_range(63),
                     $urandom_range(63));
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      push(wmu_pkg::OP_ROOT, $urandom_range(63), $urandom_range(15), rand_val(),
           $urandom_range(63), $urandom_range(63));
    end else if (r < 40) begin
      if ($urandom_range(9) < 7) write_matrix($urandom_range(gen_n - 1));
      else push(wmu_pkg::OP_LOCAL, pick_node(gen_n), $urandom_range(15), rand_val(),
                $urandom_range(63), $urandom_range(63));
    end else if (r < 55) begin
      push(wmu_pkg::OP_LINK, pick_node(gen_n), $urandom_range(15), $urandom,
           pick_node(gen_n), pick_node(gen_n));
    end else if (r < 64) begin
      safe_update();
    end else if (r < 93) begin
      safe_read();
    end else begin
      push(3'($urandom_range(OP_SPARE_A, OP_SPARE_C)), $urandom_range(63),
           $urandom_range(15), $urandom, $urandom_range(63), $urandom_range(63));
    end
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && expected_replies.size() == 0 && !start && !busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_count(input logic [6:0] v);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pr_count = (v == 0) ? 1 : (v > 64) ? 64 : int'(v);
    gen_n = pr_count;
  endtask

  initial begin
    logic [6:0] counts [7];
    counts = '{7'd3, 7'd0, 7'd127, 7'd8, 7'd1, 7'd64, 7'd5};
    for (int i = 0; i < 1024; i++) begin
      pr_local[i] = '0;
      pr_world[i] = '0;
    end
    for (int i = 0; i < 64; i++) begin
      pr_child[i] = '0; pr_par[i] = '0; lk_child[i] = '0; lk_par[i] = '0;
    end
    for (int i = 0; i < 16; i++) pr_root[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_count(7'd2);
    // Saturating extreme-value products and sums, bad writes and reads, spare op codes.
    push(wmu_pkg::OP_ROOT, 0, 0, 32'h7fffffff, 0, 0);
    push(wmu_pkg::OP_ROOT, 0, 5, 32'h80000000, 0, 0);
    push(wmu_pkg::OP_LOCAL, 0, 0, 32'h7fffffff, 0, 0);
    push(wmu_pkg::OP_LOCAL, 0, 15, 32'h80000000, 0, 0);
    push(wmu_pkg::OP_LOCAL, 2, 3, 32'h12345678, 0, 0);
    push(wmu_pkg::OP_LINK, 0, 0, 0, 0, 0);
    push(wmu_pkg::OP_LINK, 1, 0, 0, 2, 0);
    push(wmu_pkg::OP_LINK, 0, 0, 0, 1, 0);
    push(wmu_pkg::OP_READ, 63, 15, 0, 0, 0);
    push(OP_SPARE_A, 63, 15, 32'hffffffff, 63, 63);
    push(OP_SPARE_B, 0, 0, 0, 0, 0);
    push(OP_SPARE_C, 1, 1, 1, 1, 1);
    safe_update();
    push(wmu_pkg::OP_READ, 0, 0, 0, 0, 0);
    push(wmu_pkg::OP_READ, 0, 15, 0, 0, 0);
    push(wmu_pkg::OP_READ, 0, 5, 0, 0, 0);
    push(wmu_pkg::OP_READ, 2, 0, 0, 0, 0);

    issued = 0;
    foreach (counts[i]) begin
      set_count(counts[i]);
      idle_pct = (i == 3) ? 0 : 20;
      while (issued < (i + 1) * 115) random_item();
    end

    drain();
    repeat (20) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $error("%0d expected result words never arrived", expected_replies.size());
      failures++;
    end
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
